@@ hw/rtl/vgb_pkg.sv @@
// ============================================================================
// vgb_pkg
// Types, constants and shared definitions of the volume blur block.
// ============================================================================
package vgb_pkg;

    localparam logic [16:0] Q16_ONE   = 17'h10000;

    // voxel width, fixed by the payload fields
    localparam int VOXEL_BITS = 8;

    // register indexes
    localparam logic [2:0] REG_SIZE_X   = 3'd0;
    localparam logic [2:0] REG_SIZE_Y   = 3'd1;
    localparam logic [2:0] REG_SIZE_Z   = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_W_ONE    = 3'd4;
    localparam logic [2:0] REG_W_TWO    = 3'd5;
    localparam logic [2:0] REG_W_THREE  = 3'd6;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

    typedef struct packed {
        logic       command;
        logic [4:0] pos_x;
        logic [4:0] pos_y;
        logic [4:0] pos_z;
        logic [7:0] voxel_in;
    } vgb_in_t;

    typedef struct packed {
        logic [4:0] out_x;
        logic [4:0] out_y;
        logic [4:0] out_z;
        logic [7:0] blurred;
    } vgb_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_OUTPUT
    } vgb_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input item
        logic load;      // write the latched voxel
        logic init;      // clear sums, set offsets to minus radius
        logic step;      // issue one neighbour and advance offsets
        logic div_start; // start the divider
        logic out_load;  // move the quotient into the output register
    } vgb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // current offset is the last one of the cube
        logic pipe_empty; // no neighbour still in flight
        logic div_done;
    } vgb_stat_t;

endpackage

@@ hw/rtl/vgb_ctrl.sv @@
// ============================================================================
// vgb_ctrl
// Sequencer of the volume blur: load, neighbour scan, divide, output.
// ============================================================================
module vgb_ctrl
    import vgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_command,
    output logic      in_stall,
    input  logic      out_busy,
    output vgb_cmd_t  cmd,
    input  vgb_stat_t stat
);

    vgb_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_command == CMD_FILTER)
                    begin
                        state_next = ST_START;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                cmd.init   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/vgb_div.sv @@
// ============================================================================
// vgb_div
// Restoring divider, one quotient bit per cycle, result clamped to the voxel max.
// ============================================================================
module vgb_div
    import vgb_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 48,
    parameter int VOXEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic                  done,
    output logic [VOXEL_BITS-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             zero_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   shifted;

    assign shifted = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= num;
            rem_reg  <= '0;
            den_reg  <= den;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = !busy_reg && !start;

    // zero denominator gives zero, otherwise clamp
    always_comb
    begin
        if (zero_reg)
        begin
            quot = '0;
        end
        else if (q_reg[NUM_W-1:VOXEL_BITS] != '0)
        begin
            quot = '1;
        end
        else
        begin
            quot = q_reg[VOXEL_BITS-1:0];
        end
    end

endmodule

@@ hw/rtl/vgb_datapath.sv @@
// ============================================================================
// vgb_datapath
// Volume store, neighbour scan counters, weight and accumulate pipeline.
// ============================================================================
module vgb_datapath
    import vgb_pkg::*;
#(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32,
    parameter int MAX_RADIUS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  vgb_in_t     in_item,
    input  vgb_cmd_t    cmd,
    output vgb_stat_t   stat,
    input  logic [5:0]  size_x,
    input  logic [5:0]  size_y,
    input  logic [5:0]  size_z,
    input  logic [1:0]  radius,
    input  logic [16:0] weight_one,
    input  logic [16:0] weight_two,
    input  logic [16:0] weight_three,
    input  logic        div_start,
    output vgb_out_t    result
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DEN_W = 48;
    localparam int NUM_W = DEN_W + VOXEL_BITS;

    // captured item
    vgb_in_t item_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
    end

    // effective configuration
    logic signed [7:0] sx, sy, sz;
    logic signed [3:0] r_eff;
    logic [16:0]       w1, w2, w3;
    always_comb
    begin
        sx = (int'(size_x) > MAX_X) ? 8'(MAX_X) : {2'b00, size_x};
        sy = (int'(size_y) > MAX_Y) ? 8'(MAX_Y) : {2'b00, size_y};
        sz = (int'(size_z) > MAX_Z) ? 8'(MAX_Z) : {2'b00, size_z};
        r_eff = (int'(radius) > MAX_RADIUS) ? 4'(MAX_RADIUS) : {2'b00, radius};
        w1 = (weight_one   > Q16_ONE) ? Q16_ONE : weight_one;
        w2 = (weight_two   > Q16_ONE) ? Q16_ONE : weight_two;
        w3 = (weight_three > Q16_ONE) ? Q16_ONE : weight_three;
    end

    function automatic logic [16:0] axis_f(input logic signed [3:0] d,
                                           input logic [16:0] a1,
                                           input logic [16:0] a2,
                                           input logic [16:0] a3);
        logic [3:0] m;
        m = d[3] ? 4'(-d) : d;
        case (m)
            4'd0:    axis_f = Q16_ONE;
            4'd1:    axis_f = a1;
            4'd2:    axis_f = a2;
            4'd3:    axis_f = a3;
            default: axis_f = '0;
        endcase
    endfunction

    // volume store: load write port and scan read port
    logic [VOXEL_BITS-1:0] mem [DEPTH];
    logic [VOXEL_BITS-1:0] rd_reg;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic                  wr_ok;

    assign wr_ok = (int'(item_reg.pos_x) < MAX_X) && (int'(item_reg.pos_y) < MAX_Y)
                && (int'(item_reg.pos_z) < MAX_Z);
    assign wr_addr = AW'((int'(item_reg.pos_z) * MAX_Y + int'(item_reg.pos_y)) * MAX_X
                   + int'(item_reg.pos_x));

    logic load_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_d_reg <= 1'b0;
        end
        else
        begin
            load_d_reg <= cmd.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_d_reg && wr_ok)
        begin
            mem[wr_addr] <= item_reg.voxel_in;
        end
        rd_reg <= mem[rd_addr];
    end

    // scan offsets, x fastest
    logic signed [3:0] dx_reg, dy_reg, dz_reg;
    logic signed [7:0] nx, ny, nz;
    logic              inb;
    always_comb
    begin
        nx  = 8'(signed'({1'b0, item_reg.pos_x})) + 8'(dx_reg);
        ny  = 8'(signed'({1'b0, item_reg.pos_y})) + 8'(dy_reg);
        nz  = 8'(signed'({1'b0, item_reg.pos_z})) + 8'(dz_reg);
        inb = (nx >= 0) && (nx < sx) && (ny >= 0) && (ny < sy) && (nz >= 0) && (nz < sz);
        rd_addr = AW'((int'(nz[6:0]) * MAX_Y + int'(ny[6:0])) * MAX_X + int'(nx[6:0]));
    end

    assign stat.scan_last = (dx_reg == r_eff) && (dy_reg == r_eff) && (dz_reg == r_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            dx_reg <= -r_eff;
            dy_reg <= -r_eff;
            dz_reg <= -r_eff;
        end
        else if (cmd.step)
        begin
            if (dx_reg != r_eff)
            begin
                dx_reg <= dx_reg + 4'sd1;
            end
            else
            begin
                dx_reg <= -r_eff;
                if (dy_reg != r_eff)
                begin
                    dy_reg <= dy_reg + 4'sd1;
                end
                else
                begin
                    dy_reg <= -r_eff;
                    dz_reg <= dz_reg + 4'sd1;
                end
            end
        end
    end

    // stage 1: factors and read issue
    logic        v1_reg, v2_reg, v3_reg;
    logic [16:0] fx1_reg, fy1_reg, fz1_reg, fx2_reg;
    logic [33:0] pzy_reg;
    logic [16:0] fzy;
    logic [33:0] w_full;
    logic [16:0] w_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [VOXEL_BITS+16:0] term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step && inb;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign stat.pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    always_ff @(posedge clk)
    begin
        fx1_reg <= axis_f(dx_reg, w1, w2, w3);
        fy1_reg <= axis_f(dy_reg, w1, w2, w3);
        fz1_reg <= axis_f(dz_reg, w1, w2, w3);
    end

    // stage 2: z times y, voxel arrives
    logic [VOXEL_BITS-1:0] vox2_reg, vox3_reg;
    always_ff @(posedge clk)
    begin
        pzy_reg  <= fz1_reg * fy1_reg;
        fx2_reg  <= fx1_reg;
        vox2_reg <= rd_reg;
    end
    assign fzy = pzy_reg[32:16];

    // stage 3: times x
    assign w_full = fzy * fx2_reg;
    always_ff @(posedge clk)
    begin
        w_reg    <= w_full[32:16];
        vox3_reg <= vox2_reg;
    end

    // accumulate
    assign term = w_reg * vox3_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (v3_reg)
        begin
            num_reg <= num_reg + NUM_W'(term);
            den_reg <= den_reg + DEN_W'(w_reg);
        end
    end

    // divider
    logic [VOXEL_BITS-1:0] quot;
    logic                  div_done;
    vgb_div #(
        .NUM_W      (NUM_W),
        .DEN_W      (DEN_W),
        .VOXEL_BITS (VOXEL_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );
    assign stat.div_done = div_done;

    assign result.out_x   = item_reg.pos_x;
    assign result.out_y   = item_reg.pos_y;
    assign result.out_z   = item_reg.pos_z;
    assign result.blurred = quot;

endmodule

@@ hw/rtl/volume_gaussian_blur.sv @@
// ============================================================================
// volume_gaussian_blur
// 3D Gaussian blur over a voxel store with border renormalization.
// ============================================================================
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    vgb_in_t
//  out       output     out_valid/out_stall  vgb_out_t
//  apb       input      psel/penable/pwrite  7 registers at 4*i
//
// a load is accepted while idle and written into the store on the next
// cycle, so loads can follow back to back. after a filter is accepted the
// input stalls while the block scans the cube with one neighbour read per
// cycle, drains the three stage weight pipe, runs the bit-serial division
// and loads the output register once that register is free.
// reset clears control state; the store is undefined until loaded.
// the output register holds a result while out_stall is high.
module volume_gaussian_blur
    import vgb_pkg::*;
#(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32,
    parameter int MAX_RADIUS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  vgb_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output vgb_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [1:0]  radius_reg;
    logic [16:0] w1_reg, w2_reg, w3_reg;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
            radius_reg <= 2'd1;
            w1_reg     <= 17'd39750;
            w2_reg     <= 17'd8869;
            w3_reg     <= 17'd728;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_SIZE_X:  size_x_reg <= pwdata[5:0];
                REG_SIZE_Y:  size_y_reg <= pwdata[5:0];
                REG_SIZE_Z:  size_z_reg <= pwdata[5:0];
                REG_RADIUS:  radius_reg <= pwdata[1:0];
                REG_W_ONE:   w1_reg     <= pwdata[16:0];
                REG_W_TWO:   w2_reg     <= pwdata[16:0];
                REG_W_THREE: w3_reg     <= pwdata[16:0];
                default:     ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (ridx)
            REG_SIZE_X:  prdata = {26'd0, size_x_reg};
            REG_SIZE_Y:  prdata = {26'd0, size_y_reg};
            REG_SIZE_Z:  prdata = {26'd0, size_z_reg};
            REG_RADIUS:  prdata = {30'd0, radius_reg};
            REG_W_ONE:   prdata = {15'd0, w1_reg};
            REG_W_TWO:   prdata = {15'd0, w2_reg};
            REG_W_THREE: prdata = {15'd0, w3_reg};
            default:     prdata = '0;
        endcase
    end

    vgb_cmd_t  cmd;
    vgb_stat_t stat;
    vgb_out_t  result;

    vgb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_stall   (in_stall),
        .out_busy   (out_valid && out_stall),
        .cmd        (cmd),
        .stat       (stat)
    );

    vgb_datapath #(
        .MAX_X      (MAX_X),
        .MAX_Y      (MAX_Y),
        .MAX_Z      (MAX_Z),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_data),
        .cmd          (cmd),
        .stat         (stat),
        .size_x       (size_x_reg),
        .size_y       (size_y_reg),
        .size_z       (size_z_reg),
        .radius       (radius_reg),
        .weight_one   (w1_reg),
        .weight_two   (w2_reg),
        .weight_three (w3_reg),
        .div_start    (cmd.div_start),
        .result       (result)
    );

    // output register
    logic     out_valid_reg;
    vgb_out_t out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
